// File: rtl/core/tsw_pkg.sv
// Types and constants shared by the tar stream entry walker.
package tsw_pkg;

  localparam int unsigned BlockLast   = 511;
  localparam int unsigned SizeOffset  = 124;
  localparam int unsigned SizeDigits  = 12;
  localparam int unsigned NameBytes   = 100;
  localparam int unsigned TypeOffset  = 156;
  localparam int unsigned PrefixLen   = 8;
  localparam int unsigned SizeW       = 36;

  localparam logic [7:0] CharNul   = 8'h00;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharSeven = 8'h37;
  localparam logic [7:0] CharDir   = 8'h35;

  localparam logic [3:0] PrefixFail = 4'd15;

  typedef enum logic [3:0] {
    PH_HEADER = 4'b0001,
    PH_DATA   = 4'b0010,
    PH_PAD    = 4'b0100,
    PH_STOP   = 4'b1000
  } phase_e;

  typedef enum logic [1:0] {
    ROLE_HEADER  = 2'd0,
    ROLE_KEEP    = 2'd1,
    ROLE_SKIP    = 2'd2,
    ROLE_IGNORED = 2'd3
  } role_e;

  typedef enum logic [1:0] {
    ST_RUNNING   = 2'd0,
    ST_OK        = 2'd1,
    ST_TRUNCATED = 2'd2,
    ST_BAD_PATH  = 2'd3
  } status_e;

  function automatic logic [7:0] prefix_char(input logic [2:0] idx);
    logic [7:0] c;
    unique case (idx)
      3'd0: c = 8'h43;
      3'd1: c = 8'h6f;
      3'd2: c = 8'h6e;
      3'd3: c = 8'h74;
      3'd4: c = 8'h65;
      3'd5: c = 8'h6e;
      3'd6: c = 8'h74;
      3'd7: c = 8'h2f;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// File: rtl/core/tsw_stream_if.sv
// Valid/ready channels for archive bytes in and tagged bytes out.
interface tsw_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface tsw_out_if import tsw_pkg::*;;
  logic             valid;
  logic             ready;
  logic [7:0]       byte_out;
  logic [1:0]       byte_role;
  logic             entry_ready;
  logic             entry_is_dir;
  logic [SizeW-1:0] entry_size;
  logic             content_last;
  logic [1:0]       status;

  modport source (output valid, output byte_out, output byte_role, output entry_ready,
                  output entry_is_dir, output entry_size, output content_last,
                  output status, input ready);
  modport sink   (input valid, input byte_out, input byte_role, input entry_ready,
                  input entry_is_dir, input entry_size, input content_last,
                  input status, output ready);
endinterface

// File: rtl/core/tar_stream_entry_walker.sv
// Tar stream entry walker: tags each archive byte and reports entries and status.
// One archive byte is taken per cycle unless the output stalls, and its tagged result
// appears in the output register on the next cycle; a byte is taken whenever the
// output register is empty or being drained, so throughput is one item per clock while
// the output is not stalled. All header parsing (name prefix, octal size, type flag,
// all-zero test) and the content countdown are done by the per-byte update between the
// walker state and the output register. Status is sticky once the walker stops, and
// all walker state returns to its reset value after the item flagged as the last byte.
module tar_stream_entry_walker import tsw_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  tsw_in_if.sink        in_i,
  tsw_out_if.source     out_o
);

  phase_e           phase_q, phase_d;
  logic [8:0]       block_offset_q, block_offset_d;
  logic [SizeW-1:0] size_accum_q, size_accum_d;
  logic             size_open_q, size_open_d;
  logic [SizeW-1:0] content_left_q, content_left_d;
  logic             all_zero_q, all_zero_d;
  logic [3:0]       prefix_q, prefix_d;
  logic             name_ended_q, name_ended_d;
  logic             name_ok_q, name_ok_d;
  logic             dir_flag_q, dir_flag_d;
  status_e          status_q, status_d;

  logic             out_valid_q;
  logic [7:0]       byte_q;
  role_e            role_q, role_d;
  logic             ready_q, ready_d;
  logic             is_dir_q, is_dir_d;
  logic [SizeW-1:0] esize_q, esize_d;
  logic             clast_q, clast_d;
  status_e          out_st_q;

  logic             accept;
  logic [7:0]       b;
  logic [8:0]       offset_inc;
  logic [SizeW-1:0] left_dec;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;
  assign b          = in_i.data_byte;
  assign offset_inc = block_offset_q + 9'd1;
  assign left_dec   = content_left_q - SizeW'(1);

  always_comb begin
    phase_d        = phase_q;
    block_offset_d = block_offset_q;
    size_accum_d   = size_accum_q;
    size_open_d    = size_open_q;
    content_left_d = content_left_q;
    all_zero_d     = all_zero_q;
    prefix_d       = prefix_q;
    name_ended_d   = name_ended_q;
    name_ok_d      = name_ok_q;
    dir_flag_d     = dir_flag_q;
    status_d       = status_q;
    role_d         = ROLE_HEADER;
    ready_d        = 1'b0;
    is_dir_d       = 1'b0;
    esize_d        = '0;
    clast_d        = 1'b0;

    unique case (phase_q)
      PH_HEADER: begin
        role_d = ROLE_HEADER;
        if (b != CharNul) all_zero_d = 1'b0;
        if (block_offset_q < 9'(NameBytes) && !name_ended_q) begin
          if (b == CharNul) begin
            name_ended_d = 1'b1;
            if (prefix_q == 4'd7) name_ok_d = 1'b1;
          end else if (prefix_q < 4'(PrefixLen)) begin
            if (b == prefix_char(prefix_q[2:0])) begin
              prefix_d = prefix_q + 4'd1;
              if (prefix_q == 4'(PrefixLen - 1)) name_ok_d = 1'b1;
            end else begin
              prefix_d = PrefixFail;
            end
          end
        end
        if (block_offset_q >= 9'(SizeOffset) && block_offset_q < 9'(SizeOffset + SizeDigits)
            && size_open_q) begin
          if (b == CharNul || b == CharSpace) begin
            size_open_d = 1'b0;
          end else if (b >= CharZero && b <= CharSeven) begin
            size_accum_d = {size_accum_q[SizeW-4:0], 3'b000} + SizeW'(b[2:0]);
          end
        end
        if (block_offset_q == 9'(TypeOffset)) dir_flag_d = (b == CharDir);
        if (block_offset_q == 9'(BlockLast)) begin
          block_offset_d = '0;
          if (all_zero_d) begin
            status_d = ST_OK;
            phase_d  = PH_STOP;
          end else if (!name_ok_d) begin
            status_d = ST_BAD_PATH;
            phase_d  = PH_STOP;
          end else begin
            ready_d        = 1'b1;
            is_dir_d       = dir_flag_d;
            esize_d        = size_accum_d;
            content_left_d = size_accum_d;
            if (size_accum_d == '0) begin
              phase_d = PH_HEADER;
              if (in_i.last_byte) status_d = ST_OK;
            end else begin
              phase_d = PH_DATA;
              if (in_i.last_byte) status_d = ST_TRUNCATED;
            end
          end
          size_accum_d = '0;
          size_open_d  = 1'b1;
          all_zero_d   = 1'b1;
          prefix_d     = '0;
          name_ended_d = 1'b0;
          name_ok_d    = 1'b0;
        end else begin
          block_offset_d = offset_inc;
          if (in_i.last_byte) status_d = ST_OK;
        end
      end
      PH_DATA: begin
        role_d         = dir_flag_q ? ROLE_SKIP : ROLE_KEEP;
        block_offset_d = offset_inc;
        content_left_d = left_dec;
        if (left_dec == '0) begin
          clast_d = 1'b1;
          phase_d = (offset_inc == '0) ? PH_HEADER : PH_PAD;
          if (in_i.last_byte) status_d = ST_OK;
        end else if (in_i.last_byte) begin
          status_d = ST_TRUNCATED;
        end
      end
      PH_PAD: begin
        role_d         = ROLE_SKIP;
        block_offset_d = offset_inc;
        if (offset_inc == '0) phase_d = PH_HEADER;
        if (in_i.last_byte) status_d = ST_OK;
      end
      PH_STOP: begin
        role_d = ROLE_IGNORED;
      end
      default: begin
        role_d = ROLE_IGNORED;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= PH_HEADER;
      block_offset_q <= '0;
      size_accum_q   <= '0;
      size_open_q    <= 1'b1;
      content_left_q <= '0;
      all_zero_q     <= 1'b1;
      prefix_q       <= '0;
      name_ended_q   <= 1'b0;
      name_ok_q      <= 1'b0;
      dir_flag_q     <= 1'b0;
      status_q       <= ST_RUNNING;
    end else if (accept) begin
      if (in_i.last_byte) begin
        phase_q        <= PH_HEADER;
        block_offset_q <= '0;
        size_accum_q   <= '0;
        size_open_q    <= 1'b1;
        content_left_q <= '0;
        all_zero_q     <= 1'b1;
        prefix_q       <= '0;
        name_ended_q   <= 1'b0;
        name_ok_q      <= 1'b0;
        dir_flag_q     <= 1'b0;
        status_q       <= ST_RUNNING;
      end else begin
        phase_q        <= phase_d;
        block_offset_q <= block_offset_d;
        size_accum_q   <= size_accum_d;
        size_open_q    <= size_open_d;
        content_left_q <= content_left_d;
        all_zero_q     <= all_zero_d;
        prefix_q       <= prefix_d;
        name_ended_q   <= name_ended_d;
        name_ok_q      <= name_ok_d;
        dir_flag_q     <= dir_flag_d;
        status_q       <= status_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q   <= b;
      role_q   <= role_d;
      ready_q  <= ready_d;
      is_dir_q <= is_dir_d;
      esize_q  <= esize_d;
      clast_q  <= clast_d;
      out_st_q <= status_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.byte_out     = byte_q;
  assign out_o.byte_role    = role_q;
  assign out_o.entry_ready  = ready_q;
  assign out_o.entry_is_dir = is_dir_q;
  assign out_o.entry_size   = esize_q;
  assign out_o.content_last = clast_q;
  assign out_o.status       = out_st_q;

  a_ready_role: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.entry_ready |-> out_o.byte_role == ROLE_HEADER)
    else $error("entry flagged on a non-header byte");

  a_last_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_i.last_byte |=> phase_q == PH_HEADER && status_q == ST_RUNNING
      && block_offset_q == '0)
    else $error("state not cleared after last byte");

  a_data_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_DATA |-> content_left_q != '0)
    else $error("content phase with nothing left");

  a_stop_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_STOP |-> status_q != ST_RUNNING && status_q != ST_TRUNCATED)
    else $error("stopped without a final status");

  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready |=> out_o.valid && $stable(out_o.status)
      && $stable(out_o.byte_out))
    else $error("stalled result changed");

endmodule

// File: tb/tb_tar_stream_entry_walker.sv
// Self-checking testbench for the tar stream entry walker: archive stimulus, scoreboard, checks.
`timescale 1ns / 1ps

module tb_tar_stream_entry_walker;
  import tsw_pkg::*;

  localparam int unsigned CycleLimit = 1_500_000;
  localparam int unsigned RandItems  = 1900;
  localparam int unsigned LongHold   = 400;
  localparam int unsigned MaxReports = 200;
  localparam logic [63:0] PrefixText = "Content/";

  typedef struct packed {
    logic [7:0]       data;
    role_e            role;
    logic             entry_ok;
    logic             is_dir;
    logic [SizeW-1:0] size;
    logic             clast;
    status_e          stat;
  } walk_result_t;

  typedef enum int {
    SZ_NUL,
    SZ_SPACE,
    SZ_FULL,
    SZ_JUNK,
    SZ_LEAD_SPACE,
    SZ_NOISE
  } size_fmt_e;

  class walk_scoreboard;
    phase_e           phase;
    logic [8:0]       offs;
    logic [SizeW-1:0] size_acc;
    logic [SizeW-1:0] left;
    logic             size_open;
    logic             all_zero;
    logic             name_done;
    logic             name_good;
    logic             is_dir;
    logic [3:0]       prefix_cnt;
    status_e          stat;
    walk_result_t     pending_q[$];
    int               errors;

    function new();
      errors = 0;
      restart();
    endfunction

    function void clear_header();
      size_acc   = '0;
      size_open  = 1'b1;
      all_zero   = 1'b1;
      prefix_cnt = '0;
      name_done  = 1'b0;
      name_good  = 1'b0;
    endfunction

    function void restart();
      phase  = PH_HEADER;
      offs   = '0;
      left   = '0;
      is_dir = 1'b0;
      stat   = ST_RUNNING;
      clear_header();
    endfunction

    function int pending();
      return pending_q.size();
    endfunction

    function role_e note_byte(logic [7:0] b, logic lst);
      walk_result_t r;
      r      = '0;
      r.data = b;
      r.role = ROLE_HEADER;
      case (phase)
        PH_HEADER: begin
          if (b != CharNul) all_zero = 1'b0;
          if (offs < NameBytes && !name_done) begin
            if (b == CharNul) begin
              name_done = 1'b1;
              if (prefix_cnt == PrefixLen - 1) name_good = 1'b1;
            end else if (prefix_cnt < PrefixLen) begin
              if (b == PrefixText[8 * (PrefixLen - 1 - prefix_cnt) +: 8]) begin
                prefix_cnt++;
                if (prefix_cnt == PrefixLen) name_good = 1'b1;
              end else begin
                prefix_cnt = PrefixFail;
              end
            end
          end
          if (offs >= SizeOffset && offs < SizeOffset + SizeDigits && size_open) begin
            if (b == CharNul || b == CharSpace) size_open = 1'b0;
            else if (b >= CharZero && b <= CharSeven) size_acc = (size_acc << 3) + SizeW'(b[2:0]);
          end
          if (offs == TypeOffset) is_dir = (b == CharDir);
          if (offs == BlockLast) begin
            offs = '0;
            if (all_zero) begin
              stat  = ST_OK;
              phase = PH_STOP;
            end else if (!name_good) begin
              stat  = ST_BAD_PATH;
              phase = PH_STOP;
            end else begin
              r.entry_ok = 1'b1;
              r.is_dir   = is_dir;
              r.size     = size_acc;
              left       = size_acc;
              if (size_acc == 0) begin
                phase = PH_HEADER;
                if (lst) stat = ST_OK;
              end else begin
                phase = PH_DATA;
                if (lst) stat = ST_TRUNCATED;
              end
            end
            clear_header();
          end else begin
            offs = offs + 9'd1;
            if (lst) stat = ST_OK;
          end
        end
        PH_DATA: begin
          r.role = is_dir ? ROLE_SKIP : ROLE_KEEP;
          offs   = offs + 9'd1;
          left   = left - 1'b1;
          if (left == 0) begin
            r.clast = 1'b1;
            phase   = (offs == 0) ? PH_HEADER : PH_PAD;
            if (lst) stat = ST_OK;
          end else if (lst) begin
            stat = ST_TRUNCATED;
          end
        end
        PH_PAD: begin
          r.role = ROLE_SKIP;
          offs   = offs + 9'd1;
          if (offs == 0) phase = PH_HEADER;
          if (lst) stat = ST_OK;
        end
        default: begin
          r.role = ROLE_IGNORED;
        end
      endcase
      r.stat = stat;
      pending_q.push_back(r);
      if (lst) restart();
      return r.role;
    endfunction

    function void cmp_field(string fname, logic [SizeW-1:0] want, logic [SizeW-1:0] got);
      if (got !== want) begin
        if (errors < MaxReports)
          $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, want, got);
        errors++;
      end
    endfunction

    function void check_result(walk_result_t got);
      walk_result_t want;
      if (pending_q.size() == 0) begin
        if (errors < MaxReports)
          $display("%0t: result with nothing expected, expected none, actual byte %0h",
                   $time, got.data);
        errors++;
        return;
      end
      want = pending_q.pop_front();
      cmp_field("byte_out", want.data, got.data);
      cmp_field("byte_role", want.role, got.role);
      cmp_field("entry_ready", want.entry_ok, got.entry_ok);
      cmp_field("entry_is_dir", want.is_dir, got.is_dir);
      cmp_field("entry_size", want.size, got.size);
      cmp_field("content_last", want.clast, got.clast);
      cmp_field("status", want.stat, got.stat);
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  tsw_in_if  in_if ();
  tsw_out_if out_if ();

  tar_stream_entry_walker dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  walk_scoreboard sb;
  logic [7:0]     arch_q[$];
  logic [7:0]     name_q[$];
  int             live_items = 0;
  bit             burst = 1'b0;
  bit             hold_req = 1'b0;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic logic [7:0] letter();
    return 8'h61 + 8'($urandom_range(0, 25));
  endfunction

  function automatic void set_name(string s);
    name_q.delete();
    foreach (s[i]) name_q.push_back(s[i]);
  endfunction

  function automatic void make_name(bit good);
    int k;
    if (good) begin
      case ($urandom_range(0, 3))
        0: set_name("Content");
        1: begin
          set_name("Content/");
          while (name_q.size() < NameBytes) name_q.push_back(letter());
        end
        default: begin
          set_name("Content/");
          repeat ($urandom_range(0, 20)) name_q.push_back(8'($urandom_range(1, 255)));
        end
      endcase
    end else begin
      case ($urandom_range(0, 3))
        0: set_name("");
        1: begin
          set_name("Content/");
          k = $urandom_range(0, 7);
          name_q[k] = name_q[k] ^ 8'($urandom_range(1, 255));
          if (name_q[k] == CharNul) name_q[k] = 8'h7f;
        end
        2: begin
          set_name("Content");
          name_q.push_back(letter());
        end
        default: begin
          set_name("");
          repeat ($urandom_range(1, 12)) name_q.push_back(letter());
        end
      endcase
    end
  endfunction

  function automatic void put_header(size_fmt_e fmt, logic [SizeW-1:0] sz, logic [7:0] tflag,
                                     bit noisy);
    logic [7:0] blk [BlockLast + 1];
    logic [7:0] fld [$];
    string      digits;
    int         i;
    foreach (blk[j]) blk[j] = (noisy && $urandom_range(0, 3) == 0) ? 8'($urandom) : CharNul;
    for (i = 0; i < NameBytes; i++) blk[i] = (i < name_q.size()) ? name_q[i] : CharNul;
    case (fmt)
      SZ_NUL:  digits = $sformatf("%011o", sz);
      SZ_FULL: digits = $sformatf("%012o", sz);
      default: digits = $sformatf("%0o", sz);
    endcase
    if (fmt == SZ_LEAD_SPACE) fld.push_back(CharSpace);
    foreach (digits[j]) begin
      if (fmt == SZ_JUNK)
        fld.push_back($urandom_range(0, 2) == 0 ? 8'h78 : 8'h38 + 8'($urandom_range(0, 1)));
      fld.push_back(digits[j]);
    end
    if (fmt == SZ_SPACE) fld.push_back(CharSpace);
    if (fmt == SZ_NOISE) begin
      fld.delete();
      repeat (SizeDigits)
        fld.push_back($urandom_range(0, 1) ? CharZero + 8'($urandom_range(0, 9)) : 8'($urandom));
    end
    for (i = 0; i < SizeDigits; i++) blk[SizeOffset + i] = (i < fld.size()) ? fld[i] : CharNul;
    blk[TypeOffset] = tflag;
    foreach (blk[j]) arch_q.push_back(blk[j]);
  endfunction

  function automatic void put_body(int n);
    repeat (n) arch_q.push_back(8'($urandom));
    while (arch_q.size() % (BlockLast + 1) != 0) arch_q.push_back(8'($urandom));
  endfunction

  function automatic void put_zero_block();
    repeat (BlockLast + 1) arch_q.push_back(CharNul);
  endfunction

  function automatic void add_entry(size_fmt_e fmt, logic [SizeW-1:0] sz, logic [7:0] tflag,
                                    bit noisy);
    put_header(fmt, sz, tflag, noisy);
    case (fmt)
      SZ_LEAD_SPACE: put_body(0);
      SZ_NOISE:      put_body($urandom_range(0, 30));
      default:       put_body(int'(sz));
    endcase
  endfunction

  task automatic send_byte(logic [7:0] b, logic lst);
    int gap;
    if ($urandom_range(0, 299) == 0) burst = !burst;
    gap = burst ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.data_byte <= b;
    in_if.last_byte <= lst;
    do @(posedge clk_i); while (!in_if.ready);
    if (sb.note_byte(b, lst) != ROLE_IGNORED) live_items++;
  endtask

  task automatic send_archive(int cut);
    int stop_at;
    int i;
    stop_at = (cut < 0 || cut >= arch_q.size()) ? arch_q.size() - 1 : cut;
    for (i = 0; i <= stop_at; i++) send_byte(arch_q[i], i == stop_at);
    arch_q.delete();
  endtask

  task automatic wait_idle();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  task automatic directed_archives();
    put_zero_block();
    repeat (5) arch_q.push_back(8'hff);
    send_archive(-1);

    hold_req = 1'b1;
    set_name("Content");
    add_entry(SZ_NUL, 0, CharDir, 1'b0);
    set_name("Content/a.bin");
    add_entry(SZ_SPACE, 5, CharZero, 1'b1);
    set_name("Content/dir/");
    add_entry(SZ_NUL, 3, CharDir, 1'b1);
    put_zero_block();
    send_archive(-1);

    set_name("Content/");
    while (name_q.size() < NameBytes) name_q.push_back(letter());
    add_entry(SZ_FULL, 512, CharZero, 1'b1);
    set_name("Content/x");
    add_entry(SZ_JUNK, 513, CharZero, 1'b0);
    put_zero_block();
    send_archive(-1);

    set_name("Contents");
    add_entry(SZ_NUL, 4, CharZero, 1'b0);
    arch_q.push_back(8'h00);
    arch_q.push_back(8'hff);
    send_archive(-1);

    set_name("");
    add_entry(SZ_NUL, 1, CharZero, 1'b1);
    send_archive(BlockLast);

    set_name("Content/big");
    put_header(SZ_FULL, '1, CharZero, 1'b0);
    repeat (7) arch_q.push_back(8'($urandom));
    send_archive(-1);

    set_name("Content/t");
    add_entry(SZ_NUL, 10, CharZero, 1'b0);
    send_archive(BlockLast);

    set_name("Content/z");
    add_entry(SZ_NUL, 0, CharZero, 1'b0);
    send_archive(BlockLast);

    put_zero_block();
    send_archive(BlockLast);

    set_name("Content/p");
    add_entry(SZ_NUL, 0, CharZero, 1'b1);
    send_archive(300);

    arch_q.push_back(8'hff);
    send_archive(-1);

    set_name("Content/c");
    add_entry(SZ_SPACE, 20, CharZero, 1'b1);
    send_archive(BlockLast + 11);
    set_name("Content/c");
    add_entry(SZ_SPACE, 20, CharZero, 1'b1);
    send_archive(BlockLast + 20);
    set_name("Content/c");
    add_entry(SZ_SPACE, 20, CharZero, 1'b1);
    send_archive(BlockLast + 100);

    set_name("Content/l");
    add_entry(SZ_LEAD_SPACE, 7, CharZero, 1'b0);
    put_zero_block();
    send_archive(-1);

    set_name("Conten");
    add_entry(SZ_NUL, 2, CharZero, 1'b0);
    send_archive(-1);
    set_name("Content_x");
    add_entry(SZ_NUL, 2, CharZero, 1'b1);
    send_archive(-1);

    set_name("Content/n");
    add_entry(SZ_NOISE, 0, 8'hff, 1'b1);
    put_zero_block();
    send_archive(-1);

    set_name("Content/d/");
    add_entry(SZ_NUL, 530, CharDir, 1'b1);
    put_zero_block();
    send_archive(-1);
  endtask

  task automatic random_archive();
    int               pick;
    logic [SizeW-1:0] sz;
    size_fmt_e        fmt;
    logic [7:0]       tflag;
    repeat ($urandom_range(1, 2)) begin
      make_name($urandom_range(0, 7) != 0);
      pick = $urandom_range(0, 19);
      if (pick < 10) sz = $urandom_range(1, 40);
      else if (pick < 13) sz = '0;
      else if (pick < 16) sz = $urandom_range(500, 530);
      else sz = $urandom_range(41, 300);
      fmt = size_fmt_e'($urandom_range(0, 4));
      if ($urandom_range(0, 15) == 0) fmt = SZ_NOISE;
      pick  = $urandom_range(0, 7);
      tflag = (pick < 2) ? CharDir : (pick == 7) ? 8'($urandom) : CharZero;
      add_entry(fmt, sz, tflag, $urandom_range(0, 1));
    end
    if ($urandom_range(0, 3) != 0) put_zero_block();
    repeat ($urandom_range(0, 12)) arch_q.push_back(8'($urandom));
    send_archive($urandom_range(0, 4) < 3 ? -1 : $urandom_range(0, arch_q.size() - 1));
  endtask

  initial begin : result_side
    int           stall;
    walk_result_t got;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      stall = burst ? 0 : $urandom_range(0, 8);
      if (hold_req) begin
        hold_req = 1'b0;
        stall    = LongHold;
      end
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
      got.data     = out_if.byte_out;
      got.role     = role_e'(out_if.byte_role);
      got.entry_ok = out_if.entry_ready;
      got.is_dir   = out_if.entry_is_dir;
      got.size     = out_if.entry_size;
      got.clast    = out_if.content_last;
      got.stat     = status_e'(out_if.status);
      sb.check_result(got);
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : stimulus
    int rand_start;
    bit paused;
    sb = new();
    in_if.valid     <= 1'b0;
    in_if.data_byte <= 8'h00;
    in_if.last_byte <= 1'b0;
    out_if.ready    <= 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    directed_archives();
    wait_idle();
    rand_start = live_items;
    paused     = 1'b0;
    while (live_items - rand_start < RandItems) begin
      random_archive();
      if (!paused && live_items - rand_start >= RandItems / 2) begin
        wait_idle();
        paused = 1'b1;
      end
    end
    wait_idle();
    repeat (8) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
